FILE: rtl/core/udec_pkg.sv
// Shared types and constants for the UTF-8 validating decoder.
// No dependencies; the front, queue, back and top-level files import this package.
package udec_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [20:0] REPLACEMENT_CHAR = 21'h00FFFD;
   localparam logic [30:0] MAX_SCALAR       = 31'h0010FFFF;
   localparam logic [30:0] SURROGATE_LO     = 31'h0000D800;
   localparam logic [30:0] SURROGATE_HI     = 31'h0000DFFF;

   // One queue entry holds everything one byte produced: an optional close of
   // a broken pending sequence (always rejected) and an optional main result
   // whose value still has to be screened. A forced rejection carries value 0,
   // which the screen always rejects.
   typedef struct packed {
      logic        close_valid;
      logic [2:0]  close_count;
      logic        main_valid;
      logic [30:0] main_value;
      logic [2:0]  main_len;
   } entry_type;

endpackage

FILE: rtl/core/udec_channels.sv
// Valid/ready channel interfaces for the byte input and the decoded result.
// Depends on nothing; used by the front, back and top-level modules.
interface udec_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       buffer_end;

   modport source (output valid, data_byte, buffer_end, input ready);
   modport sink   (input valid, data_byte, buffer_end, output ready);
endinterface

interface udec_rsp_if;
   logic        valid;
   logic        ready;
   logic [20:0] code_point;
   logic        invalid;
   logic [2:0]  byte_count;
   logic        last_of_run;

   modport source (output valid, code_point, invalid, byte_count, last_of_run, input ready);
   modport sink   (input valid, code_point, invalid, byte_count, last_of_run, output ready);
endinterface

FILE: rtl/core/udec_front.sv
// Front end: accepts bytes, tracks the pending sequence, builds queue entries.
// Depends on udec_pkg and udec_req_if.
module udec_front (
   input  logic                 clock,
   input  logic                 reset,
   udec_req_if.sink             req_bus,
   input  logic                 queue_not_full,
   output logic                 push,
   output udec_pkg::entry_type  push_entry
);
   import udec_pkg::*;

   logic [30:0] acc_ff, acc_in;
   logic [2:0]  rem_ff, rem_in;
   logic [2:0]  taken_ff, taken_in;

   logic [7:0]  b;
   logic        accept;
   logic [2:0]  lead_rem;
   logic [4:0]  lead_bits;
   logic [30:0] cont_acc;
   logic [2:0]  cont_taken;
   logic        run_lead;
   entry_type   entry;

   assign req_bus.ready = queue_not_full;
   assign accept        = req_bus.valid & queue_not_full;
   assign b             = req_bus.data_byte;
   assign cont_acc      = {acc_ff[24:0], b[5:0]};
   assign cont_taken    = taken_ff + 3'd1;

   // Lead byte decode; zero remaining marks a stray or invalid lead.
   always_comb begin
      lead_rem  = 3'd0;
      lead_bits = 5'd0;
      if (b[7:5] == 3'b110) begin
         lead_rem  = 3'd1;
         lead_bits = b[4:0];
      end else if (b[7:4] == 4'b1110) begin
         lead_rem  = 3'd2;
         lead_bits = {1'b0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
         lead_rem  = 3'd3;
         lead_bits = {2'b0, b[2:0]};
      end else if (b[7:2] == 6'b111110) begin
         lead_rem  = 3'd4;
         lead_bits = {3'b0, b[1:0]};
      end else if (b[7:1] == 7'b1111110) begin
         lead_rem  = 3'd5;
         lead_bits = {4'b0, b[0]};
      end
   end

   always_comb begin
      entry          = '0;
      entry.main_len = 3'd1;
      acc_in         = acc_ff;
      rem_in         = rem_ff;
      taken_in       = taken_ff;
      run_lead       = 1'b0;

      if (rem_ff != 3'd0) begin
         if (b[7:6] == 2'b10) begin
            if (rem_ff == 3'd1) begin
               entry.main_valid = 1'b1;
               entry.main_value = cont_acc;
               entry.main_len   = cont_taken;
               acc_in           = '0;
               rem_in           = 3'd0;
               taken_in         = 3'd0;
            end else if (req_bus.buffer_end) begin
               entry.main_valid = 1'b1;
               entry.main_len   = cont_taken;
               acc_in           = '0;
               rem_in           = 3'd0;
               taken_in         = 3'd0;
            end else begin
               acc_in   = cont_acc;
               rem_in   = rem_ff - 3'd1;
               taken_in = cont_taken;
            end
         end else begin
            // drop the broken sequence, then decode this byte as a lead
            entry.close_valid = 1'b1;
            entry.close_count = taken_ff;
            run_lead          = 1'b1;
         end
      end else begin
         run_lead = 1'b1;
      end

      if (run_lead) begin
         acc_in   = '0;
         rem_in   = 3'd0;
         taken_in = 3'd0;
         if (b inside {[8'h00:8'h7F]}) begin
            entry.main_valid = 1'b1;
            entry.main_value = {23'd0, b};
         end else if (lead_rem == 3'd0 || req_bus.buffer_end) begin
            entry.main_valid = 1'b1;
         end else begin
            acc_in   = {26'd0, lead_bits};
            rem_in   = lead_rem;
            taken_in = 3'd1;
         end
      end
   end

   assign push       = accept & (entry.close_valid | entry.main_valid);
   assign push_entry = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         rem_ff   <= 3'd0;
         taken_ff <= 3'd0;
      end else if (accept) begin
         acc_ff   <= acc_in;
         rem_ff   <= rem_in;
         taken_ff <= taken_in;
      end
   end

endmodule

FILE: rtl/core/udec_queue.sv
// Short FIFO of decoded entries between the front and back ends.
// Depends on udec_pkg for the entry type.
module udec_queue #(
   parameter int DEPTH = udec_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  udec_pkg::entry_type  push_entry,
   output logic                 not_full,
   input  logic                 pop,
   output logic                 not_empty,
   output udec_pkg::entry_type  head
);
   import udec_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   entry_type        slots_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;

   assign not_full  = (count_ff != CntW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/core/udec_back.sv
// Back end: screens decoded values and issues results into the output register.
// Depends on udec_pkg and udec_rsp_if.
module udec_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  udec_pkg::entry_type  head,
   output logic                 pop,
   udec_rsp_if.source           rsp_bus
);
   import udec_pkg::*;

   logic        valid_ff;
   logic [20:0] code_ff;
   logic        invalid_ff;
   logic [2:0]  count_ff;
   logic        last_ff;
   logic        phase_ff, phase_in;

   logic        take_close;
   logic [30:0] sel_value;
   logic [2:0]  sel_len;
   logic        sel_last;
   logic        sel_bad;
   logic        load;

   function automatic logic is_rejected(logic [30:0] v, logic [2:0] len);
      logic [2:0] need;
      logic       bad;
      begin
         if (v < 31'h80)             need = 3'd1;
         else if (v < 31'h800)       need = 3'd2;
         else if (v < 31'h10000)     need = 3'd3;
         else if (v < 31'h200000)    need = 3'd4;
         else if (v < 31'h4000000)   need = 3'd5;
         else                        need = 3'd6;
         bad = (v == '0) || (v[15:0] == 16'hFFFE) || (v[15:0] == 16'hFFFF) ||
               (v > MAX_SCALAR) || (v >= SURROGATE_LO && v <= SURROGATE_HI) ||
               (need != len);
         return bad;
      end
   endfunction

   // the close half of an entry goes out first
   assign take_close = head.close_valid & ~phase_ff;
   assign sel_value  = take_close ? '0 : head.main_value;
   assign sel_len    = take_close ? head.close_count : head.main_len;
   assign sel_last   = take_close ? ~head.main_valid : 1'b1;
   assign sel_bad    = is_rejected(sel_value, sel_len);

   assign load     = head_valid & (~valid_ff | rsp_bus.ready);
   assign pop      = load & sel_last;
   assign phase_in = load ? ~sel_last : phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (load) begin
            valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         code_ff    <= sel_bad ? REPLACEMENT_CHAR : sel_value[20:0];
         invalid_ff <= sel_bad;
         count_ff   <= sel_len;
         last_ff    <= sel_last;
      end
   end

   assign rsp_bus.valid       = valid_ff;
   assign rsp_bus.code_point  = code_ff;
   assign rsp_bus.invalid     = invalid_ff;
   assign rsp_bus.byte_count  = count_ff;
   assign rsp_bus.last_of_run = last_ff;

endmodule

FILE: rtl/core/utf8_validating_decoder.sv
// UTF-8 validating decoder: one byte per beat in, code points (or U+FFFD) out.
// A byte that completes a result is written into the queue, then loaded from the queue head
// into the result register, whose valid drives the result beat.
// Throughput: one byte per cycle while the queue is not full; a byte that yields two results
// issues them one after the other through the single result register.
// Reset: synchronous, active high; clears sequence state, queue and output valid.
// Depends on udec_pkg, udec_channels, udec_front, udec_queue and udec_back.
module utf8_validating_decoder #(
   parameter int QUEUE_DEPTH = udec_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   udec_req_if.sink    req_bus,
   udec_rsp_if.source  rsp_bus
);
   import udec_pkg::*;

   // Front end: classify each accepted byte and advance the sequence state.
   // Bytes that only extend a pending sequence push nothing.
   logic      q_not_full;
   logic      q_not_empty;
   logic      q_push;
   logic      q_pop;
   entry_type q_push_entry;
   entry_type q_head;

   udec_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .queue_not_full (q_not_full),
      .push           (q_push),
      .push_entry     (q_push_entry)
   );

   // Queue: decouple byte intake from result delivery so a stalled result
   // side does not stop bytes until the queue fills.
   udec_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .not_full   (q_not_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   // Back end: screen values (range, surrogate, noncharacter, NUL, overlong)
   // and issue up to two result beats per entry; advance the queue on the last.
   udec_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_not_empty),
      .head       (q_head),
      .pop        (q_pop),
      .rsp_bus    (rsp_bus)
   );

endmodule
